// File: hdl/d2b32_pkg.sv
package d2b32_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int FRAC_W = 55;
   localparam int MANT_W = 53;
   localparam int EXPO_W = 12;
   localparam int MAG_W  = 11;
   localparam int BCD_W  = 16;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [10:0] EFIELD_SPECIAL = 11'h7FF;
   localparam logic [11:0] EXP_OFFSET     = 12'd1022;
   localparam logic [11:0] SUBNORM_EXP    = 12'd0 - 12'd1021;

   typedef enum logic [1:0] {
      F_IDLE,
      F_NORM,
      F_BCD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SIGN,
      B_FRAC,
      B_HASH,
      B_ENEG,
      B_EXP,
      B_BAD
   } back_state_type;

   // one classified number on its way from front to back
   typedef struct packed {
      logic              bad;
      logic              minus;
      logic [FRAC_W-1:0] frac;
      logic              exp_neg;
      logic [BCD_W-1:0]  bcd;
   } entry_type;

   function automatic logic [7:0] digit_char(input logic [4:0] d);
      logic [7:0] dw;
      dw = {3'b000, d};
      if (d < 5'd10) begin
         return CHAR_ZERO + dw;
      end else begin
         return CHAR_LOW_A + dw - 8'd10;
      end
   endfunction

endpackage

// File: hdl/d2b32_ifs.sv
interface d2b32_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;

   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

interface d2b32_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       last_char;
   logic       bad_value;

   modport source (output valid, output text_char, output last_char, output bad_value,
                   input ready);
   modport sink (input valid, input text_char, input last_char, input bad_value,
                 output ready);
endinterface

// File: hdl/double_to_base32_text_top.sv
// Prints one binary64 bit pattern per request transaction as ASCII text, one character
// per response transaction: optional '-', base-32 fraction digits in [0.5,1) most
// significant first until the rest is zero (1 to 11), '#', then the binary exponent in
// signed decimal; zero prints "0#0", infinity and NaN give one response with bad_value
// set and text_char 0. last_char marks the final character. A front stage takes the
// request, renormalizes (8 or 1 bit per step), converts the exponent to decimal and
// queues the result, and takes no new request until the result is queued. The back
// stage pulls a queued entry and then drives one character per cycle while the response
// side is ready, 1 to 18 characters. Throughput is set by the slower of the two, with
// the queue (QUEUE_DEPTH entries) absorbing response stalls.
module double_to_base32_text_top #(
   parameter int QUEUE_DEPTH = d2b32_pkg::QUEUE_DEPTH
) (
   input logic          clock,
   input logic          reset,
   d2b32_req_if.sink    req_if,
   d2b32_rsp_if.source  rsp_if
);

   logic                 push_valid, push_ready;
   logic                 pop_valid, pop_ready;
   d2b32_pkg::entry_type push_data, pop_data;

   d2b32_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_bits    (req_if.value_bits),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   d2b32_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   d2b32_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_char  (rsp_if.text_char),
      .out_last  (rsp_if.last_char),
      .out_bad   (rsp_if.bad_value)
   );

endmodule

// File: hdl/d2b32_front.sv
module d2b32_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [63:0]          in_bits,
   output logic                 push_valid,
   input  logic                 push_ready,
   output d2b32_pkg::entry_type push_data
);

   d2b32_pkg::front_state_type state_ff, state_in;

   logic                              minus_ff, minus_in;
   logic                              bad_ff, bad_in;
   logic [d2b32_pkg::MANT_W-1:0]      mant_ff, mant_in;
   logic [d2b32_pkg::EXPO_W-1:0]      expo_ff, expo_in;
   logic                              exp_neg_ff, exp_neg_in;
   logic [d2b32_pkg::MAG_W-1:0]       mag_ff, mag_in;
   logic [d2b32_pkg::BCD_W-1:0]       bcd_ff, bcd_in;
   logic [3:0]                        cnt_ff, cnt_in;

   logic [10:0] efield;
   logic [51:0] mfield;
   logic        is_zero;
   logic        norm_done;
   logic [d2b32_pkg::BCD_W-1:0] bcd_adj;

   assign efield    = in_bits[62:52];
   assign mfield    = in_bits[51:0];
   assign is_zero   = (efield == 11'd0) && (mfield == 52'd0);
   assign norm_done = bad_ff || mant_ff[d2b32_pkg::MANT_W-1] || (mant_ff == '0);

   // double dabble: add 3 to every nibble of 5 or more before shifting
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                        : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         d2b32_pkg::F_IDLE: if (in_valid) state_in = d2b32_pkg::F_NORM;
         d2b32_pkg::F_NORM: if (norm_done) state_in = d2b32_pkg::F_BCD;
         d2b32_pkg::F_BCD:  if (cnt_ff == 4'd10) state_in = d2b32_pkg::F_PUSH;
         d2b32_pkg::F_PUSH: if (push_ready) state_in = d2b32_pkg::F_IDLE;
         default:           state_in = d2b32_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      in_ready   = (state_ff == d2b32_pkg::F_IDLE);
      push_valid = (state_ff == d2b32_pkg::F_PUSH);
   end

   always_comb begin
      minus_in   = minus_ff;
      bad_in     = bad_ff;
      mant_in    = mant_ff;
      expo_in    = expo_ff;
      exp_neg_in = exp_neg_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      cnt_in     = cnt_ff;
      unique case (state_ff)
         d2b32_pkg::F_IDLE: begin
            minus_in = in_bits[63] && !is_zero;
            bad_in   = (efield == d2b32_pkg::EFIELD_SPECIAL);
            mant_in  = {(efield != 11'd0), mfield};
            if (is_zero) begin
               expo_in = '0;
            end else if (efield != 11'd0) begin
               expo_in = {1'b0, efield} - d2b32_pkg::EXP_OFFSET;
            end else begin
               expo_in = d2b32_pkg::SUBNORM_EXP;
            end
         end
         d2b32_pkg::F_NORM: begin
            if (norm_done) begin
               exp_neg_in = expo_ff[d2b32_pkg::EXPO_W-1];
               if (expo_ff[d2b32_pkg::EXPO_W-1]) begin
                  mag_in = d2b32_pkg::MAG_W'(12'd0 - expo_ff);
               end else begin
                  mag_in = expo_ff[d2b32_pkg::MAG_W-1:0];
               end
               bcd_in = '0;
               cnt_in = '0;
            end else if (mant_ff[52:45] == 8'd0) begin
               mant_in = {mant_ff[44:0], 8'd0};
               expo_in = expo_ff - 12'd8;
            end else begin
               mant_in = {mant_ff[51:0], 1'b0};
               expo_in = expo_ff - 12'd1;
            end
         end
         d2b32_pkg::F_BCD: begin
            bcd_in = {bcd_adj[14:0], mag_ff[d2b32_pkg::MAG_W-1]};
            mag_in = {mag_ff[d2b32_pkg::MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff + 4'd1;
         end
         d2b32_pkg::F_PUSH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= d2b32_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      minus_ff   <= minus_in;
      bad_ff     <= bad_in;
      mant_ff    <= mant_in;
      expo_ff    <= expo_in;
      exp_neg_ff <= exp_neg_in;
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      cnt_ff     <= cnt_in;
   end

   always_comb begin
      push_data.bad     = bad_ff;
      push_data.minus   = minus_ff;
      push_data.frac    = {mant_ff, 2'b00};
      push_data.exp_neg = exp_neg_ff;
      push_data.bcd     = bcd_ff;
   end

endmodule

// File: hdl/d2b32_queue.sv
module d2b32_queue #(
   parameter int DEPTH = d2b32_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  d2b32_pkg::entry_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output d2b32_pkg::entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   d2b32_pkg::entry_type slots_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/d2b32_back.sv
module d2b32_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  d2b32_pkg::entry_type pop_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_char,
   output logic                 out_last,
   output logic                 out_bad
);

   d2b32_pkg::back_state_type state_ff, state_in;

   d2b32_pkg::entry_type               ent_ff, ent_in;
   logic [d2b32_pkg::FRAC_W-1:0]       frac_ff, frac_in;
   logic [1:0]                         idx_ff, idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       bad_ff, bad_in;

   logic                         out_free;
   logic                         emit;
   logic [d2b32_pkg::FRAC_W-1:0] frac_shift;
   logic [1:0]                   top_idx;
   logic [3:0]                   cur_nib;

   assign out_free   = !rsp_valid_ff || out_ready;
   assign emit       = (state_ff != d2b32_pkg::B_IDLE) && out_free;
   assign frac_shift = {frac_ff[d2b32_pkg::FRAC_W-6:0], 5'd0};

   // position of the leading nonzero exponent digit, at least the ones digit
   always_comb begin
      if (ent_ff.bcd[15:12] != 4'd0) begin
         top_idx = 2'd3;
      end else if (ent_ff.bcd[11:8] != 4'd0) begin
         top_idx = 2'd2;
      end else if (ent_ff.bcd[7:4] != 4'd0) begin
         top_idx = 2'd1;
      end else begin
         top_idx = 2'd0;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd3:    cur_nib = ent_ff.bcd[15:12];
         2'd2:    cur_nib = ent_ff.bcd[11:8];
         2'd1:    cur_nib = ent_ff.bcd[7:4];
         default: cur_nib = ent_ff.bcd[3:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         d2b32_pkg::B_IDLE: begin
            if (pop_valid) begin
               if (pop_data.bad) begin
                  state_in = d2b32_pkg::B_BAD;
               end else if (pop_data.minus) begin
                  state_in = d2b32_pkg::B_SIGN;
               end else begin
                  state_in = d2b32_pkg::B_FRAC;
               end
            end
         end
         d2b32_pkg::B_SIGN: if (out_free) state_in = d2b32_pkg::B_FRAC;
         d2b32_pkg::B_FRAC: if (out_free && frac_shift == '0) state_in = d2b32_pkg::B_HASH;
         d2b32_pkg::B_HASH: begin
            if (out_free) begin
               state_in = ent_ff.exp_neg ? d2b32_pkg::B_ENEG : d2b32_pkg::B_EXP;
            end
         end
         d2b32_pkg::B_ENEG: if (out_free) state_in = d2b32_pkg::B_EXP;
         d2b32_pkg::B_EXP:  if (out_free && idx_ff == 2'd0) state_in = d2b32_pkg::B_IDLE;
         d2b32_pkg::B_BAD:  if (out_free) state_in = d2b32_pkg::B_IDLE;
         default:           state_in = d2b32_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = (state_ff == d2b32_pkg::B_IDLE);
      char_in   = d2b32_pkg::CHAR_NUL;
      last_in   = 1'b0;
      bad_in    = 1'b0;
      unique case (state_ff)
         d2b32_pkg::B_IDLE: begin
         end
         d2b32_pkg::B_SIGN: char_in = d2b32_pkg::CHAR_MINUS;
         d2b32_pkg::B_FRAC: char_in = d2b32_pkg::digit_char(frac_ff[54:50]);
         d2b32_pkg::B_HASH: char_in = d2b32_pkg::CHAR_HASH;
         d2b32_pkg::B_ENEG: char_in = d2b32_pkg::CHAR_MINUS;
         d2b32_pkg::B_EXP: begin
            char_in = d2b32_pkg::CHAR_ZERO + {4'd0, cur_nib};
            last_in = (idx_ff == 2'd0);
         end
         d2b32_pkg::B_BAD: begin
            last_in = 1'b1;
            bad_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ent_in       = ent_ff;
      frac_in      = frac_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (pop_valid && pop_ready) begin
         ent_in  = pop_data;
         frac_in = pop_data.frac;
      end
      if (state_ff == d2b32_pkg::B_FRAC && out_free) begin
         frac_in = frac_shift;
      end
      if (state_ff == d2b32_pkg::B_HASH && out_free) begin
         idx_in = top_idx;
      end
      if (state_ff == d2b32_pkg::B_EXP && out_free) begin
         idx_in = idx_ff - 2'd1;
      end
      if (out_free) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= d2b32_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff  <= ent_in;
      frac_ff <= frac_in;
      idx_ff  <= idx_in;
      if (emit) begin
         char_ff <= char_in;
         last_ff <= last_in;
         bad_ff  <= bad_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign out_bad   = bad_ff;

endmodule

// File: hdl/d2b32_checker.sv
module d2b32_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_text_char,
   input logic       rsp_last_char,
   input logic       rsp_bad_value
);

   // a stalled response transaction keeps its character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_char)
                                  && $stable(rsp_last_char) && $stable(rsp_bad_value))
      else $error("response changed while stalled");

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_value |-> rsp_last_char && (rsp_text_char == 8'h00))
      else $error("bad value response is not a lone NUL");

   a_text_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_value |-> (rsp_text_char >= 8'h23) && (rsp_text_char <= 8'h76))
      else $error("response character out of range");

   // the front is busy for a while after taking a request
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

endmodule

bind double_to_base32_text_top d2b32_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_text_char (rsp_if.text_char),
   .rsp_last_char (rsp_if.last_char),
   .rsp_bad_value (rsp_if.bad_value)
);
